// File: rtl/core/occupancy_frontier_marker_macros.svh
// Assertion macros for the occupancy frontier marker.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef OCCUPANCY_FRONTIER_MARKER_MACROS_SVH
`define OCCUPANCY_FRONTIER_MARKER_MACROS_SVH
`ifndef SYNTH
// Checked property, disabled while reset is high
`define OFM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset
`define OFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFM_ASSERT(lbl, clk, rst, prop, msg)
`define OFM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/ofm_pkg.sv
// Shared types and constants of the occupancy frontier marker.
// No dependencies; imported by every module of the block.
package ofm_pkg;

   // Field and port widths
   localparam int CFG_W        = 11;
   localparam int CELL_W       = 8;
   localparam int CELL_INDEX_W = 20;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 24;
   localparam int RSP_PAD_W    = RSP_DATA_W - CELL_INDEX_W - 1;
   localparam int CSR_ADDR_W   = 1;

   // Map size limits and reset size
   localparam int MIN_DIM   = 3;
   localparam int RESET_DIM = 1024;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_HEIGHT = 1'd1;

   // Request kinds carried on tuser
   localparam logic REQ_CELL  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Occupancy codes
   localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;
   localparam logic signed [CELL_W-1:0] CELL_FREE    = 8'sd0;

   // What the window needs of one cell: free, or an unknown cell inside the
   // eligible index range
   typedef struct packed {
      logic free_c;
      logic unk;
   } ofm_entry_type;

   // One line buffer word: cells one row and two rows above
   typedef struct packed {
      ofm_entry_type upper;
      ofm_entry_type lower;
   } ofm_pair_type;

   // One window column, newest row on top
   typedef struct packed {
      ofm_entry_type top;
      ofm_entry_type mid;
      ofm_entry_type bot;
   } ofm_column_type;

   // Control of the item between the front stage and the window stage
   typedef struct packed {
      logic          valid;
      logic          emit;
      logic          last;
      logic          mask_upper;
      logic          mask_lower;
      ofm_entry_type entry;
   } ofm_ctl_type;

endpackage

// File: rtl/core/ofm_line_mem.sv
// Line buffer memory: one word per column, holding two rows of cell entries.
// Depends on ofm_pkg for the word type.
module ofm_line_mem #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output ofm_pkg::ofm_pair_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ofm_pkg::ofm_pair_type wr_data
);
   import ofm_pkg::*;

   ofm_pair_type line_mem [DEPTH];
   ofm_pair_type rd_data_ff;

   // Synchronous write, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ofm_front.sv
// Front stage: size registers, raster position tracking, cell classification
// and line buffer read issue. Depends on ofm_pkg and the assertion macros.
`include "occupancy_frontier_marker_macros.svh"
module ofm_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int AW = $clog2(MAX_WIDTH),
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1),
   localparam int FW = (PW > ofm_pkg::CELL_INDEX_W) ? PW : ofm_pkg::CELL_INDEX_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ofm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ofm_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            take,
   input  logic                            req_type,
   input  logic signed [ofm_pkg::CELL_W-1:0] cell_value,
   input  logic                            s1_go,
   output logic                            drop,
   output logic                            rd_en,
   output logic [AW-1:0]                   rd_addr,
   output ofm_pkg::ofm_ctl_type            s1_ctl,
   output logic [AW-1:0]                   s1_addr,
   output logic [FW-1:0]                   s1_index
);
   import ofm_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int RW1 = RW + 1;
   localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
   localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   ofm_ctl_type   s1_ctl_ff, s1_ctl_in;
   logic [AW-1:0] s1_addr_ff;
   logic [FW-1:0] s1_index_ff;

   logic [WW-1:0]  clamp_w;
   logic [HW-1:0]  clamp_h;
   logic [RW1-1:0] rx;
   logic [RW1-1:0] hx;
   logic           in_frame;
   logic           col_nz;
   logic           col_last;
   logic           past_first;
   logic           above_last;
   logic           is_last;
   logic           keep;
   ofm_entry_type  entry;

   // Clamp written sizes into the supported range
   always_comb begin
      if (csr_wdata < CFG_W'(MIN_DIM)) begin
         clamp_w = WW'(MIN_DIM);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         clamp_w = WW'(MAX_WIDTH);
      end else begin
         clamp_w = WW'(csr_wdata);
      end
      if (csr_wdata < CFG_W'(MIN_DIM)) begin
         clamp_h = HW'(MIN_DIM);
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         clamp_h = HW'(MAX_HEIGHT);
      end else begin
         clamp_h = HW'(csr_wdata);
      end
   end

   // Size register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_MAP_WIDTH:  width_in  = clamp_w;
            REG_MAP_HEIGHT: height_in = clamp_h;
            default: ;
         endcase
      end
   end

   // Position of the incoming item: row, column and linear index
   assign rx         = RW1'(row_ff);
   assign hx         = RW1'(height_ff);
   assign in_frame   = rx < hx;
   assign col_nz     = col_ff != '0;
   assign col_last   = col_ff == AW'(width_ff - WW'(1));
   assign past_first = (rx >= RW1'(2)) || ((rx == RW1'(1)) && col_nz);
   assign above_last = (rx + RW1'(2)) <= hx;
   assign is_last    = (rx == (hx + RW1'(1))) && !col_nz;

   // A flush inside the frame is discarded; a surplus cell acts as a flush
   assign drop = take && in_frame && (req_type == REQ_FLUSH);
   assign keep = take && !drop;

   // Classify the cell; only unknown cells in the eligible range count
   always_comb begin
      entry.free_c = in_frame && (cell_value == CELL_FREE);
      entry.unk    = above_last && past_first && (cell_value == CELL_UNKNOWN);
   end

   // Raster counters
   always_comb begin
      pos_in = pos_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (csr_we) begin
         pos_in = '0;
         row_in = '0;
         col_in = '0;
      end else if (keep) begin
         if (is_last) begin
            pos_in = '0;
            row_in = '0;
            col_in = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
      end
   end

   // Hand-off register to the window stage
   always_comb begin
      s1_ctl_in = s1_ctl_ff;
      if (keep) begin
         s1_ctl_in.valid      = 1'b1;
         s1_ctl_in.emit       = past_first;
         s1_ctl_in.last       = is_last;
         s1_ctl_in.mask_upper = rx >= RW1'(1);
         s1_ctl_in.mask_lower = rx >= RW1'(2);
         s1_ctl_in.entry      = entry;
      end else if (s1_go) begin
         s1_ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RST_W);
         height_ff <= HW'(RST_H);
         pos_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         s1_ctl_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Payload of the hand-off: column address and judged cell index
   always_ff @(posedge clock) begin
      if (keep) begin
         s1_addr_ff  <= col_ff;
         s1_index_ff <= FW'(pos_ff) - FW'(width_ff) - FW'(1);
      end
   end

   // The line buffer word for this column is read as the item enters
   assign rd_en    = keep;
   assign rd_addr  = col_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_addr  = s1_addr_ff;
   assign s1_index = s1_index_ff;

   `OFM_ASSERT(a_col_in_row, clock, reset, WW'(col_ff) < width_ff, "column past map width")
   `OFM_ASSERT(a_frame_restart, clock, reset, keep && is_last && !csr_we |=> (pos_ff == '0) && (row_ff == '0), "frame did not restart after last cell")
   `OFM_ASSERT(a_rw_same_word, clock, reset, keep && s1_go && (s1_addr_ff == col_ff) |-> (row_ff == '0), "same-word read and write outside the first row")

endmodule

// File: rtl/core/ofm_window.sv
// Window stage: 3x3 neighborhood registers, line buffer write-back, frontier
// decision and result register. Depends on ofm_pkg.
module ofm_window #(
   parameter int FW = 21
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ofm_pkg::ofm_ctl_type               s1_ctl,
   input  logic [FW-1:0]                      s1_index,
   input  logic                               s1_go,
   input  ofm_pkg::ofm_pair_type              rd_data,
   output logic                               wr_en,
   output ofm_pkg::ofm_pair_type              wr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_valid,
   output logic [ofm_pkg::CELL_INDEX_W-1:0]   rsp_index,
   output logic                               rsp_frontier,
   output logic                               rsp_last
);
   import ofm_pkg::*;

   ofm_column_type col0;
   ofm_column_type col1_ff, col1_in;
   ofm_column_type col2_ff, col2_in;
   logic           frontier;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CELL_INDEX_W-1:0] rsp_index_ff;
   logic           rsp_frontier_ff;
   logic           rsp_last_ff;

   // Newest column: incoming cell plus the two rows above, masked where those
   // rows lie before the start of the frame
   always_comb begin
      col0.top = s1_ctl.entry;
      col0.mid = s1_ctl.mask_upper ? rd_data.upper : '0;
      col0.bot = s1_ctl.mask_lower ? rd_data.lower : '0;
   end

   // Write back: this cell becomes the upper row, the upper row moves down
   assign wr_en         = s1_go;
   assign wr_data.upper = col0.top;
   assign wr_data.lower = col0.mid;

   // Center is the middle of the previous column; the other eight neighbor it
   assign frontier = col1_ff.mid.free_c &&
                     (col0.top.unk || col0.mid.unk || col0.bot.unk ||
                      col1_ff.top.unk || col1_ff.bot.unk ||
                      col2_ff.top.unk || col2_ff.mid.unk || col2_ff.bot.unk);

   // Window shift
   always_comb begin
      col1_in = col1_ff;
      col2_in = col2_ff;
      if (s1_go) begin
         col1_in = col0;
         col2_in = col1_ff;
      end
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col1_ff      <= '0;
         col2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col1_ff      <= col1_in;
         col2_ff      <= col2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_go && s1_ctl.emit) begin
         rsp_index_ff    <= s1_index[CELL_INDEX_W-1:0];
         rsp_frontier_ff <= frontier;
         rsp_last_ff     <= s1_ctl.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_frontier = rsp_frontier_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: rtl/core/occupancy_frontier_marker.sv
// Occupancy frontier marker, top level: stream ports, handshake glue and the
// front, line buffer and window units. Depends on ofm_pkg and the macros.
//
// Usage: grid cells enter on the req_ channel in raster order, one per
// transaction (tdata = cell value, tuser = 0), followed by W+1 flush
// transactions (tuser = 1) to drain the last rows. Each cell index f gets one
// rsp_ transaction carrying the index and the frontier flag; tlast marks the
// final cell of the map, after which a new frame starts.
// The csr_ port writes map width (index 0) and height (index 1); a write also
// restarts the frame. Write only while the block is idle.
// The result for cell f passes the hand-off register and then the result
// register once position f+W+1 is accepted, and waits while a result is held.
// Throughput: one transaction per cycle while no result is held back, set
// by one read and one write of the line buffer word per column, on separate ports.
// Reset clears the counters, the window and the size registers (1024 x 1024,
// clamped to the maximum); the line buffer needs no clearing because rows
// before the start of a frame are masked on read.
// When rsp_tready is low with a result held, transactions without a result
// still pass; the first that carries one waits in the hand-off stage and
// req_tready stays low until the held result is taken.
`include "occupancy_frontier_marker_macros.svh"
module occupancy_frontier_marker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_we,
   input  logic [ofm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ofm_pkg::CFG_W-1:0]        csr_wdata,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ofm_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] cell_value
   input  logic                             req_tuser,  // [0] req_type
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ofm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [19:0] cell_index, [20] is_frontier
   output logic                             rsp_tlast   // last_cell
);
   import ofm_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
   localparam int FW = (PW > CELL_INDEX_W) ? PW : CELL_INDEX_W;

   logic signed [CELL_W-1:0] cell_value;
   logic                     take;
   logic                     drop;
   logic                     s1_go;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   ofm_pair_type             rd_data;
   logic                     wr_en;
   ofm_pair_type             wr_data;
   ofm_ctl_type              s1_ctl;
   logic [AW-1:0]            s1_addr;
   logic [FW-1:0]            s1_index;
   logic [CELL_INDEX_W-1:0]  rsp_index;
   logic                     rsp_frontier;

   assign cell_value = req_tdata;

   // Hand-off stage moves unless it carries a result that cannot be placed
   assign s1_go      = s1_ctl.valid && (!s1_ctl.emit || !rsp_tvalid || rsp_tready);
   assign req_tready = !s1_ctl.valid || s1_go;
   assign take       = req_tvalid && req_tready;

   ofm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .take       (take),
      .req_type   (req_tuser),
      .cell_value (cell_value),
      .s1_go      (s1_go),
      .drop       (drop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .s1_ctl     (s1_ctl),
      .s1_addr    (s1_addr),
      .s1_index   (s1_index)
   );

   ofm_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data)
   );

   ofm_window #(
      .FW (FW)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .s1_ctl       (s1_ctl),
      .s1_index     (s1_index),
      .s1_go        (s1_go),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_data      (wr_data),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_index    (rsp_index),
      .rsp_frontier (rsp_frontier),
      .rsp_last     (rsp_tlast)
   );

   // Result packing
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_frontier, rsp_index};

   `OFM_ASSERT(a_blocked_stalls_input, clock, reset, s1_ctl.valid && s1_ctl.emit && rsp_tvalid && !rsp_tready |-> !req_tready, "input taken while hand-off stage is blocked")
   `OFM_ASSERT_ALWAYS(a_silent_item_drains, clock, s1_ctl.valid && !s1_ctl.emit |-> s1_go, "item without result held in hand-off stage")
   `OFM_ASSERT(a_kept_item_staged, clock, reset, take && !drop |=> s1_ctl.valid, "accepted cell missing from hand-off stage")

endmodule

// File: sim/tb_occupancy_frontier_marker.sv
`timescale 1ns / 1ps
// Self-checking testbench for occupancy_frontier_marker: streams raster frames of grid cells,
// predicts every frontier verdict in step with the line buffer and checks the result stream.
// Depends on ofm_pkg and the occupancy_frontier_marker RTL only.
module tb_occupancy_frontier_marker;
   import ofm_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int RING_DEPTH    = 2 * MAX_WIDTH + 4;
   localparam int RANDOM_ITEMS  = 480;
   localparam int QUIET_TAIL    = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 50000;
   // ~2k transactions, each at worst a sender gap plus a receiver stall, plus holds
   localparam int CYCLE_LIMIT   = 200000;

   typedef enum logic [1:0] {
      CLASS_FREE     = 2'd0,
      CLASS_UNKNOWN  = 2'd1,
      CLASS_OCCUPIED = 2'd2
   } cell_class_type;

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] index;
      logic                    frontier;
      logic                    last;
   } cell_verdict_type;

   // DUT signals; all inputs known from time zero
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = REG_MAP_WIDTH;
   logic [CFG_W-1:0]        csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;   // [7:0] cell_value
   logic                    req_tuser  = REQ_CELL; // [0] req_type
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;         // [19:0] cell_index, [20] is_frontier
   logic                    rsp_tlast;         // last_cell

   // Verdict predictor state
   cell_class_type   class_ring [RING_DEPTH] = '{default: CLASS_FREE};
   logic [CFG_W-1:0] width_reg  = CFG_W'(RESET_DIM);
   logic [CFG_W-1:0] height_reg = CFG_W'(RESET_DIM);
   int               frame_pos  = 0;
   cell_verdict_type verdict_q [$];

   // Run bookkeeping
   int mismatches      = 0;
   int offered         = 0;
   int ignored_flushes = 0;
   int live_items      = 0;
   int frames_closed   = 0;
   int results_seen    = 0;
   int cycle_count     = 0;

   // Idling controls: 0 = none, else one chance in N per cycle (receiver) or per transaction (sender)
   int tx_gap_rate   = 0;
   int rx_gap_rate   = 0;
   int rsp_hold_left = 0;

   occupancy_frontier_marker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_dim(input int v, input int hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int map_w();
      return clamp_dim(int'(width_reg), MAX_WIDTH);
   endfunction

   function automatic int map_h();
      return clamp_dim(int'(height_reg), MAX_HEIGHT);
   endfunction

   function automatic cell_class_type classify(input logic [CELL_W-1:0] v);
      if (v == CELL_UNKNOWN) return CLASS_UNKNOWN;
      if (v == CELL_FREE) return CLASS_FREE;
      return CLASS_OCCUPIED;
   endfunction

   // Unknown cell at index u, counted only inside the eligible index range
   function automatic bit eligible_unknown(input int u, input int w, input int n);
      if (u < w + 1 || u > n - w - 1) return 1'b0;
      return class_ring[u % RING_DEPTH] == CLASS_UNKNOWN;
   endfunction

   // Advance the frame by one accepted transaction; queue the verdict it releases
   task automatic predict_verdict(input logic kind, input logic [CELL_W-1:0] val,
                                  output bit ignored);
      int w, n, p, f;
      bit frontier;
      cell_verdict_type v;
      w = map_w();
      n = w * map_h();
      p = frame_pos;
      ignored = 1'b0;
      if (p < n) begin
         // early flush: no effect at all
         if (kind == REQ_FLUSH) begin
            ignored = 1'b1;
            return;
         end
         class_ring[p % RING_DEPTH] = classify(val);
      end
      // beyond the last cell, anything counts as padding
      frame_pos = p + 1;
      if (p < w + 1) return;
      f = p - w - 1;
      frontier = 1'b0;
      if (class_ring[f % RING_DEPTH] == CLASS_FREE) begin
         frontier = eligible_unknown(f - 1, w, n)     || eligible_unknown(f + 1, w, n)     ||
                    eligible_unknown(f - w, w, n)     || eligible_unknown(f + w, w, n)     ||
                    eligible_unknown(f - w + 1, w, n) || eligible_unknown(f + w - 1, w, n) ||
                    eligible_unknown(f - w - 1, w, n) || eligible_unknown(f + w + 1, w, n);
      end
      v.index    = CELL_INDEX_W'(f);
      v.frontier = frontier;
      v.last     = (f == n - 1);
      verdict_q  = {verdict_q, v};
      if (v.last) begin
         frame_pos = 0;
         frames_closed++;
      end
   endtask

   // ---------------------------------------------------------------- result side

   // Receiver readiness: long holds on request, random stall bursts otherwise
   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rx_gap_rate != 0 && $urandom_range(0, rx_gap_rate - 1) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every accepted result against the oldest pending verdict
   always @(posedge clock) begin : result_check
      cell_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("result for cell %0d with nothing pending",
                                      rsp_tdata[CELL_INDEX_W-1:0]));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[CELL_INDEX_W-1:0] !== want.index)
               report_mismatch($sformatf("cell_index %0d, want %0d",
                                         rsp_tdata[CELL_INDEX_W-1:0], want.index));
            if (rsp_tdata[CELL_INDEX_W] !== want.frontier)
               report_mismatch($sformatf("is_frontier %b for cell %0d, want %b",
                                         rsp_tdata[CELL_INDEX_W], want.index, want.frontier));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_cell %b for cell %0d, want %b",
                                         rsp_tlast, want.index, want.last));
            if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
               report_mismatch($sformatf("tdata pad bits %b for cell %0d",
                                         rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W], want.index));
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // Offer one transaction and wait for the handshake
   task automatic send_item(input logic kind, input logic [CELL_W-1:0] val);
      bit ignored;
      if (tx_gap_rate != 0 && $urandom_range(0, tx_gap_rate - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_verdict(kind, val, ignored);
      offered++;
      if (ignored) ignored_flushes++;
      else live_items++;
   endtask

   // Stop offering and let every pending verdict come out, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
      // a write also restarts the frame
      if (idx == REG_MAP_WIDTH) width_reg = CFG_W'(value);
      else height_reg = CFG_W'(value);
      frame_pos = 0;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_map(input int wv, input int hv);
      wait_drained();
      write_reg(REG_MAP_WIDTH, wv);
      write_reg(REG_MAP_HEIGHT, hv);
   endtask

   // Mostly unknown and free so both verdicts show up; the rest covers occupied codes
   function automatic logic [CELL_W-1:0] random_cell();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CELL_UNKNOWN;
         4, 5, 6, 7: return CELL_FREE;
         8:          return CELL_W'($urandom_range(0, 255));
         default: begin
            case ($urandom_range(0, 3))
               0:       return 8'h80;
               1:       return 8'h7F;
               2:       return 8'h01;
               default: return 8'hFE;
            endcase
         end
      endcase
   endfunction

   function automatic int random_gap_rate();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 2;
         2:       return 4;
         default: return 8;
      endcase
   endfunction

   // One frame of cells and its padding; noisy frames add early flushes and surplus cells
   task automatic send_frame(input bit noisy);
      int w, n;
      w = map_w();
      n = w * map_h();
      for (int k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_item(REQ_FLUSH, CELL_W'($urandom_range(0, 255)));
         send_item(REQ_CELL, random_cell());
      end
      for (int k = 0; k <= w; k++) begin
         if (noisy && $urandom_range(0, 3) == 0)
            send_item(REQ_CELL, random_cell());
         else
            send_item(REQ_FLUSH, CELL_W'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // A few cells at the reset size; the register write of the next test must restart the frame
   task automatic test_reset_size_restart();
      tx_gap_rate = 4;
      rx_gap_rate = 4;
      for (int k = 0; k < 8; k++) send_item(REQ_CELL, random_cell());
   endtask

   // Both sizes below the minimum clamp to 3x3; hand-built grid with an early flush
   // and a surplus cell in the padding
   task automatic test_smallest_map();
      logic [CELL_W-1:0] grid [9];
      grid = '{CELL_FREE, 8'h7F, CELL_FREE, 8'h80, CELL_UNKNOWN,
               CELL_FREE, 8'h01, CELL_FREE, CELL_UNKNOWN};
      set_map(0, 2);
      for (int k = 0; k < 9; k++) begin
         if (k == 3) send_item(REQ_FLUSH, 8'hFF);
         send_item(REQ_CELL, grid[k]);
      end
      send_item(REQ_FLUSH, 8'h00);
      send_item(REQ_CELL, CELL_UNKNOWN);
      send_item(REQ_FLUSH, 8'hFF);
      send_item(REQ_FLUSH, 8'h00);
   endtask

   // After the last cell the count starts over: a flush is ignored, cells begin a frame
   task automatic test_frame_after_end();
      send_item(REQ_FLUSH, 8'h00);
      send_item(REQ_CELL, CELL_FREE);
      send_item(REQ_CELL, CELL_UNKNOWN);
      send_item(REQ_CELL, 8'h80);
      send_item(REQ_CELL, CELL_UNKNOWN);
      send_item(REQ_CELL, CELL_FREE);
   endtask

   // Register extremes: all-ones width clamps to the maximum, zero height to the
   // minimum; then an all-ones height on a narrow map. Opening rows only.
   task automatic test_size_extremes();
      tx_gap_rate = 8;
      rx_gap_rate = 8;
      set_map(2047, 0);
      // one full row of the widest map and a little more: the first verdicts come out
      for (int k = 0; k < map_w() + 16; k++) send_item(REQ_CELL, random_cell());
      set_map(3, 2047);
      for (int k = 0; k < 40; k++) send_item(REQ_CELL, random_cell());
   endtask

   // Long receiver hold while cells keep coming, and a sender pause mid-frame
   task automatic test_backpressure();
      int w, n;
      tx_gap_rate = 0;
      rx_gap_rate = 0;
      set_map(8, 16);
      w = map_w();
      n = w * map_h();
      for (int k = 0; k < 40; k++) send_item(REQ_CELL, random_cell());
      wait_drained();
      rsp_hold_left = 300;
      for (int k = 40; k < n; k++) send_item(REQ_CELL, random_cell());
      for (int k = 0; k <= w; k++) send_item(REQ_FLUSH, 8'h00);
      wait_drained();
   endtask

   // Random sizes and content; mostly clean frames, some noisy or cut short
   task automatic test_random_frames();
      int target;
      int wv, hv;
      bit first;
      target = live_items + RANDOM_ITEMS;
      first = 1'b1;
      while (live_items < target) begin
         if (target - live_items < QUIET_TAIL) begin
            tx_gap_rate = 0;
            rx_gap_rate = 0;
         end else begin
            tx_gap_rate = random_gap_rate();
            rx_gap_rate = random_gap_rate();
         end
         if (first || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       wv = $urandom_range(0, 2);
               1:       wv = MIN_DIM;
               9:       wv = $urandom_range(30, 64);
               default: wv = $urandom_range(4, 14);
            endcase
            case ($urandom_range(0, 9))
               0:       hv = $urandom_range(0, 2);
               1:       hv = MIN_DIM;
               default: hv = $urandom_range(4, 8);
            endcase
            set_map(wv, hv);
            first = 1'b0;
         end
         case ($urandom_range(0, 7))
            0: begin
               // broken frame: cut short, the next one carries on from here
               wv = $urandom_range(1, map_w() * map_h() - 1);
               for (int k = 0; k < wv; k++) send_item(REQ_CELL, random_cell());
            end
            1:       send_frame(1'b1);
            default: send_frame(1'b0);
         endcase
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : run
      int spin;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_size_restart();
      test_smallest_map();
      test_frame_after_end();
      test_size_extremes();
      test_backpressure();
      test_random_frames();

      // final drain with no idling
      tx_gap_rate = 0;
      rx_gap_rate = 0;
      req_tvalid <= 1'b0;
      spin = 0;
      while (verdict_q.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d verdicts never came out", verdict_q.size()));

      $display("Run covered %0d transactions (%0d early flushes), %0d frames, %0d results",
               offered, ignored_flushes, frames_closed, results_seen);
      $display("Map sizes from 3x3 up to the 1024 clamp, stalls on both sides, %0d cycles",
               cycle_count);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
